>>> hw/rtl/iokv_pkg.sv
// ----------------------------------------------------------------------------
// iokv_pkg
// Shared constants, codes and types of the insertion-ordered key/value table.
// ----------------------------------------------------------------------------
`default_nettype none

package iokv_pkg;

   localparam int CAPACITY = 64;

   localparam int DATA_W  = 32;
   localparam int OP_W    = 2;
   localparam int POS_W   = 6;
   localparam int ERR_W   = 2;
   localparam int IDX_W   = $clog2(CAPACITY);
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
   localparam logic [OP_W-1:0] OP_GET    = 2'd1;
   localparam logic [OP_W-1:0] OP_KEY_AT = 2'd2;

   localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
   localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_RANGE = 2'd2;

   typedef struct packed {
      logic              key_we;
      logic              val_we;
      logic [IDX_W-1:0]  waddr;
      logic [DATA_W-1:0] key_wdata;
      logic [DATA_W-1:0] val_wdata;
      logic [IDX_W-1:0]  key_raddr;
      logic [IDX_W-1:0]  val_raddr;
   } store_cmd_type;

endpackage

`default_nettype wire

>>> hw/rtl/iokv_if.sv
// ----------------------------------------------------------------------------
// iokv_req_if / iokv_rsp_if
// Valid/ready channels carrying request and response transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface iokv_req_if;
   logic                                valid;
   logic                                ready;
   logic [iokv_pkg::OP_W-1:0]           operation;
   logic signed [iokv_pkg::DATA_W-1:0]  key;
   logic signed [iokv_pkg::DATA_W-1:0]  data;
   logic signed [iokv_pkg::DATA_W-1:0]  default_value;
   logic [iokv_pkg::POS_W-1:0]          position;

   modport source (output valid, operation, key, data, default_value, position,
                   input ready);
   modport sink   (input valid, operation, key, data, default_value, position,
                   output ready);
endinterface

interface iokv_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [iokv_pkg::DATA_W-1:0]  value_out;
   logic                                found;
   logic [iokv_pkg::CNT_W-1:0]          entry_count;
   logic [iokv_pkg::ERR_W-1:0]          error;

   modport source (output valid, value_out, found, entry_count, error,
                   input ready);
   modport sink   (input valid, value_out, found, entry_count, error,
                   output ready);
endinterface

`default_nettype wire

>>> hw/rtl/iokv_store.sv
// ----------------------------------------------------------------------------
// iokv_store
// Key and value memories, one write port each (shared address) and one
// registered read port each.
// ----------------------------------------------------------------------------
`default_nettype none

module iokv_store (
   input  wire                           clock,
   input  wire iokv_pkg::store_cmd_type  cmd,
   output logic [iokv_pkg::DATA_W-1:0]   key_rd_data,
   output logic [iokv_pkg::DATA_W-1:0]   val_rd_data
);

   logic [iokv_pkg::DATA_W-1:0] key_mem [iokv_pkg::CAPACITY];
   logic [iokv_pkg::DATA_W-1:0] val_mem [iokv_pkg::CAPACITY];

   always_ff @(posedge clock) begin
      if (cmd.key_we) begin
         key_mem[cmd.waddr] <= cmd.key_wdata;
      end
      key_rd_data <= key_mem[cmd.key_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.val_we) begin
         val_mem[cmd.waddr] <= cmd.val_wdata;
      end
      val_rd_data <= val_mem[cmd.val_raddr];
   end

endmodule

`default_nettype wire

>>> hw/rtl/insertion_ordered_key_value_table_unit.sv
// ----------------------------------------------------------------------------
// insertion_ordered_key_value_table_unit
// Bounded key/value table kept in insertion order; put, get and key by
// position, scanned with a single key comparator.
// ----------------------------------------------------------------------------
//  channel | dir | handshake    | payload
//  req_if  | in  | valid/ready  | operation, key, data, default_value, position
//  rsp_if  | out | valid/ready  | value_out, found, entry_count, error
//
//  Put/get scan one slot a cycle. Key by position reads the key store, or
//  ends early when the position is out of range. Other codes go straight
//  to the response.
//  Reset clears the entry count and control; memories are not cleared.
//  A stalled response holds in the output register; the next transaction is
//  accepted meanwhile and waits in its last state until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module insertion_ordered_key_value_table_unit (
   input  wire               clock,
   input  wire               reset,
   iokv_req_if.sink          req_if,
   iokv_rsp_if.source        rsp_if
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_KADDR = 3'd2;
   localparam logic [2:0] ST_KDATA = 3'd3;
   localparam logic [2:0] ST_VDATA = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   localparam int DW = iokv_pkg::DATA_W;
   localparam int IW = iokv_pkg::IDX_W;
   localparam int CW = iokv_pkg::CNT_W;
   localparam int MW = iokv_pkg::CMP_W;

   logic [2:0]                   state_ff, state_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [iokv_pkg::OP_W-1:0]    op_ff, op_in;
   logic [DW-1:0]                key_ff, key_in;
   logic [DW-1:0]                data_ff, data_in;
   logic [DW-1:0]                dflt_ff, dflt_in;
   logic [iokv_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [CW-1:0]                scan_idx_ff, scan_idx_in;
   logic                         cmp_valid_ff, cmp_valid_in;
   logic [IW-1:0]                cmp_idx_ff, cmp_idx_in;
   logic [DW-1:0]                res_value_ff, res_value_in;
   logic                         res_found_ff, res_found_in;
   logic [iokv_pkg::ERR_W-1:0]   res_err_ff, res_err_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]                rsp_value_ff, rsp_value_in;
   logic                         rsp_found_ff, rsp_found_in;
   logic [CW-1:0]                rsp_count_ff, rsp_count_in;
   logic [iokv_pkg::ERR_W-1:0]   rsp_err_ff, rsp_err_in;

   iokv_pkg::store_cmd_type      cmd;
   logic [DW-1:0]                key_rd_data;
   logic [DW-1:0]                val_rd_data;
   logic                         hit;
   logic                         pos_ok;
   logic [MW-1:0]                key_at_addr;

   iokv_store u_store (
      .clock       (clock),
      .cmd         (cmd),
      .key_rd_data (key_rd_data),
      .val_rd_data (val_rd_data)
   );

   assign hit         = cmp_valid_ff && (key_rd_data == key_ff);
   assign pos_ok      = MW'(pos_ff) < MW'(count_ff);
   assign key_at_addr = MW'(count_ff) - MW'(1) - MW'(pos_ff);

   assign req_if.ready       = (state_ff == ST_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.value_out   = rsp_value_ff;
   assign rsp_if.found       = rsp_found_ff;
   assign rsp_if.entry_count = rsp_count_ff;
   assign rsp_if.error       = rsp_err_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      data_in      = data_ff;
      dflt_in      = dflt_ff;
      pos_in       = pos_ff;
      scan_idx_in  = scan_idx_ff;
      cmp_valid_in = cmp_valid_ff;
      cmp_idx_in   = cmp_idx_ff;
      res_value_in = res_value_ff;
      res_found_in = res_found_ff;
      res_err_in   = res_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_value_in = rsp_value_ff;
      rsp_found_in = rsp_found_ff;
      rsp_count_in = rsp_count_ff;
      rsp_err_in   = rsp_err_ff;

      cmd.key_we    = 1'b0;
      cmd.val_we    = 1'b0;
      cmd.waddr     = count_ff[IW-1:0];
      cmd.key_wdata = key_ff;
      cmd.val_wdata = data_ff;
      cmd.key_raddr = scan_idx_ff[IW-1:0];
      cmd.val_raddr = cmp_idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               op_in        = req_if.operation;
               key_in       = req_if.key;
               data_in      = req_if.data;
               dflt_in      = req_if.default_value;
               pos_in       = req_if.position;
               scan_idx_in  = '0;
               cmp_valid_in = 1'b0;
               res_value_in = '0;
               res_found_in = 1'b0;
               res_err_in   = iokv_pkg::ERR_OK;
               case (req_if.operation)
                  iokv_pkg::OP_PUT,
                  iokv_pkg::OP_GET:    state_in = ST_SCAN;
                  iokv_pkg::OP_KEY_AT: state_in = ST_KADDR;
                  default:             state_in = ST_DONE;
               endcase
            end
         end

         ST_SCAN: begin
            if (hit) begin
               res_found_in = 1'b1;
               if (op_ff == iokv_pkg::OP_PUT) begin
                  cmd.val_we = 1'b1;
                  cmd.waddr  = cmp_idx_ff;
                  state_in   = ST_DONE;
               end else begin
                  state_in   = ST_VDATA;
               end
            end else if (scan_idx_ff < count_ff) begin
               scan_idx_in  = scan_idx_ff + CW'(1);
               cmp_valid_in = 1'b1;
               cmp_idx_in   = scan_idx_ff[IW-1:0];
            end else begin
               // scan exhausted: key absent
               if (op_ff == iokv_pkg::OP_PUT) begin
                  if (count_ff < CW'(iokv_pkg::CAPACITY)) begin
                     cmd.key_we = 1'b1;
                     cmd.val_we = 1'b1;
                     count_in   = count_ff + CW'(1);
                  end else begin
                     res_err_in = iokv_pkg::ERR_FULL;
                  end
               end else begin
                  res_value_in = dflt_ff;
               end
               state_in = ST_DONE;
            end
         end

         ST_KADDR: begin
            if (pos_ok) begin
               cmd.key_raddr = key_at_addr[IW-1:0];
               state_in      = ST_KDATA;
            end else begin
               res_err_in = iokv_pkg::ERR_RANGE;
               state_in   = ST_DONE;
            end
         end

         ST_KDATA: begin
            res_value_in = key_rd_data;
            state_in     = ST_DONE;
         end

         ST_VDATA: begin
            res_value_in = val_rd_data;
            state_in     = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_value_ff;
               rsp_found_in = res_found_ff;
               rsp_count_in = count_ff;
               rsp_err_in   = res_err_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      data_ff      <= data_in;
      dflt_ff      <= dflt_in;
      pos_ff       <= pos_in;
      scan_idx_ff  <= scan_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      res_value_ff <= res_value_in;
      res_found_ff <= res_found_in;
      res_err_ff   <= res_err_in;
      rsp_value_ff <= rsp_value_in;
      rsp_found_ff <= rsp_found_in;
      rsp_count_ff <= rsp_count_in;
      rsp_err_ff   <= rsp_err_in;
   end

endmodule

`default_nettype wire
